FILE: sv/byte_stream_word_tokenizer_macros.svh
// Assertion macros for the byte stream word tokenizer checker.
`ifndef BYTE_STREAM_WORD_TOKENIZER_MACROS_SVH
`define BYTE_STREAM_WORD_TOKENIZER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BSWT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// next-cycle implication, sampled on clk, off during reset
`define BSWT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

FILE: sv/bswt_pkg.sv
// Types and constants shared by the byte stream word tokenizer.
`default_nettype none

package bswt_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W = 20;
  localparam int LC_W = 16;
  localparam int CNT_W = 16;

  localparam longint MAX_STREAM_BYTES = 64'd1048576;
  localparam longint POS_SPAN = 64'd1 << POS_W;
  localparam logic [POS_W-1:0] POS_CAP =
    POS_W'(((MAX_STREAM_BYTES < POS_SPAN) ? MAX_STREAM_BYTES : POS_SPAN) - 64'd1);

  localparam logic [LC_W-1:0] LC_MAX = '1;
  localparam logic [LC_W-1:0] LC_ONE = LC_W'(1);
  localparam logic [CNT_W-1:0] LIMIT_RST = '1;

  localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_PCT = 8'h25;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SP = 8'h20;

  localparam int QDEPTH = 4;
  localparam int QIDX_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic             token_kind;
    logic [15:0]      token_code;
    logic [POS_W-1:0] token_start;
    logic [POS_W-1:0] token_end;
    logic [LC_W-1:0]  token_line;
    logic [LC_W-1:0]  token_column;
    logic [CNT_W-1:0] token_number;
    logic             last_of_run;
  } out_item_t;

  // results produced by one byte, 0 to 2 of them, first in r0
  typedef struct packed {
    logic [1:0] n;
    out_item_t  r0;
    out_item_t  r1;
  } push_t;

endpackage

`default_nettype wire

FILE: sv/bswt_core.sv
// Tokenizer core: byte classification, position tracking and token building.
`default_nettype none

module bswt_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [bswt_pkg::CNT_W-1:0]  cfg_wdata,
  input  wire logic                        item_vld,
  input  wire bswt_pkg::in_item_t          item,
  input  wire logic                        room,
  output logic                             take,
  output bswt_pkg::push_t                  push
);

  logic [bswt_pkg::CNT_W-1:0]  limit_r;
  logic [bswt_pkg::POS_W-1:0]  off_r, off_nxt;
  logic [bswt_pkg::LC_W-1:0]   line_r, line_nxt;
  logic [bswt_pkg::LC_W-1:0]   col_r, col_nxt;
  logic                        inword_r, inword_nxt;
  logic [bswt_pkg::POS_W-1:0]  wstart_r, wstart_nxt;
  logic [bswt_pkg::LC_W-1:0]   wcol_r, wcol_nxt;
  logic [bswt_pkg::BYTE_W-1:0] wfirst_r, wfirst_nxt;
  logic [bswt_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;

  logic [bswt_pkg::BYTE_W-1:0] b;
  logic                        is_space, is_special, is_sep;
  logic [bswt_pkg::POS_W-1:0]  off_inc;
  logic                        word_req, ok_word, ok_spec;
  logic [bswt_pkg::CNT_W-1:0]  cnt_mid;
  logic [bswt_pkg::POS_W-1:0]  w_start, w_end;
  logic [bswt_pkg::LC_W-1:0]   w_col;
  logic [bswt_pkg::BYTE_W-1:0] w_first;
  bswt_pkg::out_item_t         word_tok, spec_tok;

  assign b = item.data_byte;

  always_comb begin
    is_space   = 1'b0;
    is_special = 1'b0;
    unique case (b) inside
      bswt_pkg::CH_SP, bswt_pkg::CH_TAB, bswt_pkg::CH_LF, bswt_pkg::CH_CR: begin
        is_space = 1'b1;
      end
      bswt_pkg::CH_LBRACE, bswt_pkg::CH_RBRACE, bswt_pkg::CH_BSLASH,
      bswt_pkg::CH_DOLLAR, bswt_pkg::CH_PCT: begin
        is_special = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign is_sep  = is_space | is_special;
  assign take    = item_vld & room;
  assign off_inc = (off_r >= bswt_pkg::POS_CAP) ? bswt_pkg::POS_CAP
                                                : off_r + bswt_pkg::POS_W'(1);

  // word ends on a separator, or is flushed on the last byte
  always_comb begin
    if (is_sep) begin
      word_req = inword_r;
      w_end    = off_r;
    end else begin
      word_req = item.end_of_stream;
      w_end    = off_inc;
    end
    if (inword_r) begin
      w_start = wstart_r;
      w_col   = wcol_r;
      w_first = wfirst_r;
    end else begin
      w_start = off_r;
      w_col   = col_r;
      w_first = b;
    end
  end

  assign ok_word = word_req & (cnt_r < limit_r);
  assign cnt_mid = cnt_r + bswt_pkg::CNT_W'(ok_word);
  assign ok_spec = is_special & (cnt_mid < limit_r);

  always_comb begin
    word_tok.token_kind   = 1'b1;
    word_tok.token_code   = {w_first, w_first};
    word_tok.token_start  = w_start;
    word_tok.token_end    = w_end;
    word_tok.token_line   = line_r;
    word_tok.token_column = w_col;
    word_tok.token_number = cnt_r + bswt_pkg::CNT_W'(1);
    word_tok.last_of_run  = ~ok_spec;

    spec_tok.token_kind   = 1'b1;
    spec_tok.token_code   = {b, b};
    spec_tok.token_start  = off_r;
    spec_tok.token_end    = off_inc;
    spec_tok.token_line   = line_r;
    spec_tok.token_column = col_r;
    spec_tok.token_number = cnt_mid + bswt_pkg::CNT_W'(1);
    spec_tok.last_of_run  = 1'b1;

    push.n  = take ? ({1'b0, ok_word} + {1'b0, ok_spec}) : 2'd0;
    push.r0 = ok_word ? word_tok : spec_tok;
    push.r1 = spec_tok;
  end

  always_comb begin
    off_nxt    = off_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    inword_nxt = inword_r;
    wstart_nxt = wstart_r;
    wcol_nxt   = wcol_r;
    wfirst_nxt = wfirst_r;
    cnt_nxt    = cnt_r;
    if (take) begin
      if (item.end_of_stream) begin
        off_nxt    = '0;
        line_nxt   = bswt_pkg::LC_ONE;
        col_nxt    = bswt_pkg::LC_ONE;
        inword_nxt = 1'b0;
        wstart_nxt = '0;
        wcol_nxt   = bswt_pkg::LC_ONE;
        wfirst_nxt = '0;
        cnt_nxt    = '0;
      end else begin
        off_nxt    = off_inc;
        inword_nxt = ~is_sep;
        wstart_nxt = w_start;
        wcol_nxt   = w_col;
        wfirst_nxt = w_first;
        cnt_nxt    = cnt_mid + bswt_pkg::CNT_W'(ok_spec);
        if (b == bswt_pkg::CH_LF) begin
          line_nxt = (line_r == bswt_pkg::LC_MAX) ? line_r
                                                  : line_r + bswt_pkg::LC_ONE;
          col_nxt  = bswt_pkg::LC_ONE;
        end else begin
          col_nxt  = (col_r == bswt_pkg::LC_MAX) ? col_r
                                                 : col_r + bswt_pkg::LC_ONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= bswt_pkg::LIMIT_RST;
      off_r    <= '0;
      line_r   <= bswt_pkg::LC_ONE;
      col_r    <= bswt_pkg::LC_ONE;
      inword_r <= 1'b0;
      wstart_r <= '0;
      wcol_r   <= bswt_pkg::LC_ONE;
      wfirst_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      off_r    <= off_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
      inword_r <= inword_nxt;
      wstart_r <= wstart_nxt;
      wcol_r   <= wcol_nxt;
      wfirst_r <= wfirst_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/bswt_outq.sv
// Result queue: takes up to two tokens per cycle, hands out one per cycle while out_ready is high.
`default_nettype none

module bswt_outq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire bswt_pkg::push_t      push,
  output logic                      room,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output bswt_pkg::out_item_t       out_item
);

  bswt_pkg::out_item_t           q_r [bswt_pkg::QDEPTH];
  logic [bswt_pkg::QIDX_W-1:0]   head_r, head_nxt;
  logic [bswt_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [bswt_pkg::QIDX_W-1:0]   wr0, wr1;
  logic                          pop;

  assign out_valid = (cnt_r != '0);
  assign out_item  = q_r[head_r];
  assign pop       = out_valid & out_ready;
  // two free slots needed before a byte is processed
  assign room      = (cnt_r <= bswt_pkg::QCNT_W'(bswt_pkg::QDEPTH - 2));
  assign wr0       = head_r + cnt_r[bswt_pkg::QIDX_W-1:0];
  assign wr1       = wr0 + bswt_pkg::QIDX_W'(1);
  assign head_nxt  = head_r + bswt_pkg::QIDX_W'(pop);
  assign cnt_nxt   = cnt_r + bswt_pkg::QCNT_W'(push.n) - bswt_pkg::QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      q_r[wr0] <= push.r0;
    end
    if (push.n == 2'd2) begin
      q_r[wr1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/byte_stream_word_tokenizer.sv
// Top level of the byte stream word tokenizer.
//
//   port group  dir  handshake            payload
//   in_         in   in_valid/in_ready    in_item (data_byte, end_of_stream)
//   out_        out  out_valid/out_ready  out_item (one token record)
//   cfg_        in   cfg_we               cfg_wdata (token_limit)
//
// One byte per cycle while the queue has two free slots; a byte giving two tokens
// fills two queue slots, so the rate is then set by the one-token-per-cycle output.
// Data path: input register, then core logic writes the 4-entry result queue,
// whose head entry drives out_item.
// Reset: synchronous rst_n, token_limit returns to 65535, stream state cleared.
// Stalls: the core processes a byte only with two free queue slots.
`default_nettype none

module byte_stream_word_tokenizer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire bswt_pkg::in_item_t          in_item,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output bswt_pkg::out_item_t              out_item,
  input  wire logic                        cfg_we,
  input  wire logic [bswt_pkg::CNT_W-1:0]  cfg_wdata
);

  logic                  in_vld_r, in_vld_nxt;
  bswt_pkg::in_item_t    in_item_r;
  logic                  take, room;
  bswt_pkg::push_t       push;

  assign in_ready   = ~in_vld_r | take;
  assign in_vld_nxt = (in_valid & in_ready) | (in_vld_r & ~take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
  end

  bswt_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item_vld  (in_vld_r),
    .item      (in_item_r),
    .room      (room),
    .take      (take),
    .push      (push)
  );

  bswt_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

FILE: sv/bswt_checker.sv
// Port-level checker for the byte stream word tokenizer, with its bind.
`default_nettype none

`include "byte_stream_word_tokenizer_macros.svh"

module bswt_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire bswt_pkg::out_item_t  out_item
);

  `BSWT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))
  `BSWT_ASSERT_NOW(a_code_kind, out_valid, out_item.token_kind && (out_item.token_code[15:8] == out_item.token_code[7:0]))
  `BSWT_ASSERT_NOW(a_span, out_valid, out_item.token_end >= out_item.token_start)
  `BSWT_ASSERT_NOW(a_nonzero, out_valid, (out_item.token_line != '0) && (out_item.token_column != '0) && (out_item.token_number != '0))

endmodule

bind byte_stream_word_tokenizer bswt_checker u_bswt_checker (.*);

`default_nettype wire
